// ----- sv/weighted_histogram_profile_macros.svh -----
// assertion macros shared by the weighted histogram rtl
`ifndef WEIGHTED_HISTOGRAM_PROFILE_MACROS_SVH
`define WEIGHTED_HISTOGRAM_PROFILE_MACROS_SVH

// same-cycle implication, checked on clk, quiet during reset
`define WHP_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("whp check failed");

// next-cycle implication
`define WHP_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("whp check failed");

`endif

// ----- sv/whp_pkg.sv -----
// shared types, constants and helpers of the weighted histogram
`default_nettype none
package whp_pkg;

	localparam int MAX_BINS = 256;
	localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int NB_W     = $clog2(MAX_BINS + 1);
	localparam int PROD_W   = 33 + NB_W;

	typedef enum logic [1:0] {
		MODE_FILL_VAL = 2'd0,
		MODE_FILL_IDX = 2'd1,
		MODE_CLEAR    = 2'd2,
		MODE_READ     = 2'd3
	} mode_t;

	localparam logic [1:0] CFG_X_MIN     = 2'd0;
	localparam logic [1:0] CFG_X_MAX     = 2'd1;
	localparam logic [1:0] CFG_BIN_COUNT = 2'd2;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_MISS = 2'd1;
	localparam logic [1:0] STAT_FEW  = 2'd2;

	typedef enum logic {
		OP_DIV  = 1'b0,
		OP_SQRT = 1'b1
	} iter_op_t;

	typedef struct packed {
		logic        start;
		iter_op_t    op;
		logic [63:0] a;
		logic [32:0] b;
	} iter_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] q;
	} iter_rsp_t;

	typedef struct packed {
		logic [31:0] cnt;
		logic [63:0] sq;
		logic [47:0] sum;
	} bin_rec_t;

	localparam int REC_W = $bits(bin_rec_t);

	// bin count in use: zero acts as one, clamp at the store depth
	function automatic logic [NB_W-1:0] bins_used(input logic [8:0] bc);
		logic [NB_W-1:0] r;
		if (bc == 9'd0) begin
			r = NB_W'(1);
		end else if (32'(bc) > MAX_BINS) begin
			r = NB_W'(MAX_BINS);
		end else begin
			r = NB_W'(bc);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- sv/whp_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module whp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- sv/whp_iter.sv -----
// shared bit-serial divide and square root unit
`default_nettype none
module whp_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  whp_pkg::iter_req_t  req,
	output whp_pkg::iter_rsp_t  rsp
);
	import whp_pkg::*;

	logic        busy_q;
	logic        done_q;
	iter_op_t    op_q;
	logic [63:0] acc_q;
	logic [35:0] rem_q;
	logic [63:0] quo_q;
	logic [32:0] div_q;
	logic [6:0]  cnt_q;

	logic [35:0] t;
	logic [35:0] trial;
	logic        ge;
	logic [35:0] rem_n;
	logic [63:0] acc_n;

	always_comb begin
		if (op_q == OP_DIV) begin
			t     = {rem_q[34:0], acc_q[63]};
			trial = {3'b000, div_q};
			acc_n = {acc_q[62:0], 1'b0};
		end else begin
			// restoring root: trial is 4*root + 1
			t     = {rem_q[33:0], acc_q[63:62]};
			trial = {quo_q[33:0], 2'b01};
			acc_n = {acc_q[61:0], 2'b00};
		end
		ge    = (t >= trial);
		rem_n = ge ? (t - trial) : t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 7'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			acc_q <= req.a;
			div_q <= req.b;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= (req.op == OP_DIV) ? 7'd64 : 7'd32;
		end else if (busy_q) begin
			acc_q <= acc_n;
			rem_q <= rem_n;
			quo_q <= {quo_q[62:0], ge};
			cnt_q <= cnt_q - 7'd1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.q    = quo_q;
endmodule
`default_nettype wire

// ----- sv/weighted_histogram_profile.sv -----
// top level: weighted histogram with per-bin profile statistics
`default_nettype none
`include "weighted_histogram_profile_macros.svh"
// Weighted histogram over Q16.16 samples with per-bin weight sum, squared
// weight sum and entry count. One word at a time: the input side stalls from
// acceptance until the result is loaded into the output register, and the
// next word is taken while that result still waits. Work per word comes from
// the shared divide/root unit, which retires one quotient bit or one root bit
// per cycle while busy: fill by index and clear do not use it, fill by value
// uses at most one divide, and a read of a bin with two or more entries takes
// four divides and up to three roots. Reset and clear drop per-bin valid
// flags at once, so there is no sweep after reset.
module weighted_histogram_profile (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          mode,
	input  logic signed [31:0]  sample_value,
	input  logic [9:0]          bin_index,
	input  logic signed [31:0]  weight,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [1:0]          status,
	output logic signed [47:0]  bin_sum,
	output logic [31:0]         bin_entries,
	output logic signed [31:0]  bin_mean,
	output logic [31:0]         bin_std,
	output logic [31:0]         bin_err,
	output logic [31:0]         bin_sqrt_sum,
	output logic [31:0]         total_entries
);
	import whp_pkg::*;

	typedef enum logic [16:0] {
		ST_IDLE = 17'h00001,
		ST_CLR  = 17'h00002,
		ST_BMUL = 17'h00004,
		ST_BDIV = 17'h00008,
		ST_RD   = 17'h00010,
		ST_RDW  = 17'h00020,
		ST_ADD  = 17'h00040,
		ST_MEAN = 17'h00080,
		ST_MSQ  = 17'h00100,
		ST_SQ   = 17'h00200,
		ST_D    = 17'h00400,
		ST_VDIV = 17'h00800,
		ST_STD  = 17'h01000,
		ST_EDIV = 17'h02000,
		ST_ERR  = 17'h04000,
		ST_RS   = 17'h08000,
		ST_DONE = 17'h10000
	} state_t;

	// configuration registers
	logic signed [31:0] x_min_q;
	logic signed [31:0] x_max_q;
	logic [8:0]         bin_count_q;

	// sequencer and working registers
	state_t             state_q;
	logic               launch_q;
	logic [MAX_BINS-1:0] vld_q;
	logic [31:0]        tot_q;
	mode_t              mode_q;
	logic signed [31:0] w_q;
	logic [BIN_W-1:0]   bin_q;
	logic               acc_q;
	logic [1:0]         status_q;
	logic [32:0]        dx_q;
	logic [32:0]        span_q;
	logic [PROD_W-1:0]  prod_q;
	bin_rec_t           rec_q;
	logic [63:0]        wsq_q;
	logic [47:0]        am_q;
	logic               big_q;
	logic [63:0]        msq_q;
	logic [63:0]        sq_q;
	logic [63:0]        d_q;
	logic [63:0]        var_q;
	logic signed [31:0] mean_q;
	logic [31:0]        std_q;
	logic [31:0]        err_q;
	logic [31:0]        rs_q;

	// output register
	logic               out_valid_q;
	logic               accepted_q;
	logic [1:0]         status_o_q;
	logic signed [47:0] bin_sum_q;
	logic [31:0]        bin_entries_q;
	logic signed [31:0] bin_mean_q;
	logic [31:0]        bin_std_q;
	logic [31:0]        bin_err_q;
	logic [31:0]        bin_sqrt_sum_q;
	logic [31:0]        total_entries_q;

	// combinational helpers
	logic [NB_W-1:0]    nb;
	logic [32:0]        dx;
	logic [32:0]        span;
	logic               in_rng;
	logic               idx_ok;
	iter_req_t          req;
	iter_rsp_t          rsp;
	logic [REC_W-1:0]   ram_rdata;
	logic               ram_we;
	bin_rec_t           rd_rec;
	bin_rec_t           new_rec;
	logic signed [63:0] wprod;
	logic [48:0]        s49;
	logic [64:0]        q65;
	logic [64:0]        v65;
	logic [47:0]        s_mag;
	logic               s_pos;
	logic [47:0]        q48;
	logic               fire;

	assign nb     = bins_used(bin_count_q);
	assign dx     = {sample_value[31], sample_value} - {x_min_q[31], x_min_q};
	assign span   = {x_max_q[31], x_max_q} - {x_min_q[31], x_min_q};
	assign in_rng = (sample_value >= x_min_q) && (sample_value <= x_max_q);
	assign idx_ok = (bin_index != 10'd0) && (32'(bin_index) <= 32'(nb));
	assign fire   = in_valid && !in_stall;

	assign in_stall = (state_q != ST_IDLE);

	// bin store: record read at bin_q, entries never written read as zero
	whp_ram #(
		.WIDTH (REC_W),
		.DEPTH (MAX_BINS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bin_q),
		.wdata (new_rec),
		.raddr (bin_q),
		.rdata (ram_rdata)
	);

	assign rd_rec = vld_q[bin_q] ? bin_rec_t'(ram_rdata) : '0;
	assign ram_we = (state_q == ST_ADD);

	// accumulate: saturating sum, saturating square sum, sticky count
	assign wprod = w_q * w_q;
	assign s49   = {rec_q.sum[47], rec_q.sum} + 49'(w_q);
	assign q65   = {1'b0, rec_q.sq} + {1'b0, wsq_q};

	always_comb begin
		new_rec = rec_q;
		if (s49[48] != s49[47]) begin
			new_rec.sum = s49[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
		end else begin
			new_rec.sum = s49[47:0];
		end
		new_rec.sq  = q65[64] ? '1 : q65[63:0];
		new_rec.cnt = (rec_q.cnt == '1) ? rec_q.cnt : rec_q.cnt + 32'd1;
	end

	assign s_mag = rec_q.sum[47] ? (~rec_q.sum + 48'd1) : rec_q.sum;
	assign s_pos = !rec_q.sum[47] && (rec_q.sum != '0);
	assign q48   = rsp.q[47:0];
	assign v65   = {1'b0, d_q} + {1'b0, rsp.q};

	// operand select for the shared unit
	always_comb begin
		req.start = 1'b0;
		req.op    = OP_DIV;
		req.a     = '0;
		req.b     = '0;
		case (state_q)
			ST_BDIV: begin
				req.start = !launch_q;
				req.a     = 64'(prod_q);
				req.b     = span_q;
			end
			ST_MEAN: begin
				req.start = !launch_q;
				req.a     = 64'(s_mag);
				req.b     = {1'b0, rec_q.cnt};
			end
			ST_MSQ: begin
				req.start = !launch_q;
				req.a     = rec_q.sq;
				req.b     = {1'b0, rec_q.cnt};
			end
			ST_VDIV: begin
				req.start = !launch_q;
				req.a     = d_q;
				req.b     = {1'b0, rec_q.cnt - 32'd1};
			end
			ST_STD: begin
				req.start = !launch_q;
				req.op    = OP_SQRT;
				req.a     = var_q;
			end
			ST_EDIV: begin
				req.start = !launch_q;
				req.a     = var_q;
				req.b     = {1'b0, rec_q.cnt};
			end
			ST_ERR: begin
				req.start = !launch_q;
				req.op    = OP_SQRT;
				req.a     = d_q;
			end
			ST_RS: begin
				// root of the sum only when it is positive
				req.start = !launch_q && s_pos;
				req.op    = OP_SQRT;
				req.a     = {rec_q.sum, 16'h0000};
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	whp_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q     <= 32'sd0;
			x_max_q     <= 32'sd16777216;
			bin_count_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_X_MIN:     x_min_q     <= cfg_wdata;
				CFG_X_MAX:     x_max_q     <= cfg_wdata;
				CFG_BIN_COUNT: bin_count_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			vld_q       <= '0;
			tot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.start) begin
				launch_q <= 1'b1;
			end else if (rsp.done) begin
				launch_q <= 1'b0;
			end
			// load a new result word, or drop the one taken downstream
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (fire) begin
						unique case (mode_t'(mode))
							MODE_FILL_VAL: begin
								if (!in_rng) begin
									state_q <= ST_DONE;
								end else if (span == '0) begin
									state_q <= ST_RD;
								end else begin
									state_q <= ST_BMUL;
								end
							end
							MODE_FILL_IDX, MODE_READ: begin
								state_q <= idx_ok ? ST_RD : ST_DONE;
							end
							MODE_CLEAR: state_q <= ST_CLR;
							default:    state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLR: begin
					vld_q   <= '0;
					tot_q   <= '0;
					state_q <= ST_DONE;
				end
				ST_BMUL: state_q <= ST_BDIV;
				ST_BDIV: if (rsp.done && launch_q) state_q <= ST_RD;
				ST_RD:   state_q <= ST_RDW;
				ST_RDW: begin
					if (mode_q != MODE_READ) begin
						state_q <= ST_ADD;
					end else if (rd_rec.cnt == '0) begin
						state_q <= ST_RS;
					end else begin
						state_q <= ST_MEAN;
					end
				end
				ST_ADD: begin
					vld_q[bin_q] <= 1'b1;
					if (tot_q != '1) begin
						tot_q <= tot_q + 32'd1;
					end
					state_q <= ST_DONE;
				end
				ST_MEAN: begin
					if (rsp.done && launch_q) begin
						state_q <= (rec_q.cnt == 32'd1) ? ST_RS : ST_MSQ;
					end
				end
				ST_MSQ:  if (rsp.done && launch_q) state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_D;
				ST_D:    state_q <= ST_VDIV;
				ST_VDIV: if (rsp.done && launch_q) state_q <= ST_STD;
				ST_STD:  if (rsp.done && launch_q) state_q <= ST_EDIV;
				ST_EDIV: if (rsp.done && launch_q) state_q <= ST_ERR;
				ST_ERR:  if (rsp.done && launch_q) state_q <= ST_RS;
				ST_RS: begin
					if (!s_pos || (rsp.done && launch_q)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					mode_q   <= mode_t'(mode);
					w_q      <= weight;
					dx_q     <= dx;
					span_q   <= span;
					bin_q    <= '0;
					acc_q    <= 1'b0;
					status_q <= STAT_OK;
					mean_q   <= '0;
					std_q    <= '0;
					err_q    <= '0;
					rs_q     <= '0;
					rec_q    <= '0;
					case (mode_t'(mode))
						MODE_FILL_VAL: begin
							acc_q    <= in_rng;
							status_q <= in_rng ? STAT_OK : STAT_MISS;
						end
						MODE_FILL_IDX, MODE_READ: begin
							acc_q    <= idx_ok;
							status_q <= idx_ok ? STAT_OK : STAT_MISS;
							bin_q    <= BIN_W'(bin_index - 10'd1);
						end
						default: acc_q <= 1'b0;
					endcase
				end
			end
			ST_BMUL: prod_q <= PROD_W'(dx_q) * PROD_W'(nb);
			ST_BDIV: begin
				// value equal to the top edge folds into the last bin
				if (rsp.done && launch_q) begin
					bin_q <= (rsp.q >= 64'(nb)) ? BIN_W'(nb - NB_W'(1)) : BIN_W'(rsp.q);
				end
			end
			ST_RDW: begin
				rec_q <= rd_rec;
				wsq_q <= wprod;
				if (mode_q == MODE_READ && rd_rec.cnt < 32'd2) begin
					status_q <= STAT_FEW;
				end
			end
			ST_MEAN: begin
				if (rsp.done && launch_q) begin
					am_q  <= q48;
					big_q <= (q48[47:32] != '0);
					if (!rec_q.sum[47]) begin
						mean_q <= (q48 > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : q48[31:0];
					end else begin
						mean_q <= (q48 > 48'h0000_8000_0000) ? 32'sh8000_0000
						                                     : ~q48[31:0] + 32'd1;
					end
				end
			end
			ST_MSQ:  if (rsp.done && launch_q) msq_q <= rsp.q;
			ST_SQ:   sq_q <= am_q[31:0] * am_q[31:0];
			ST_D: begin
				// negative variance estimate clamps to zero
				d_q <= (big_q || msq_q <= sq_q) ? '0 : msq_q - sq_q;
			end
			ST_VDIV: if (rsp.done && launch_q) var_q <= v65[64] ? '1 : v65[63:0];
			ST_STD:  if (rsp.done && launch_q) std_q <= rsp.q[31:0];
			ST_EDIV: if (rsp.done && launch_q) d_q <= rsp.q;
			ST_ERR:  if (rsp.done && launch_q) err_q <= rsp.q[31:0];
			ST_RS:   if (rsp.done && launch_q) rs_q <= rsp.q[31:0];
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					accepted_q      <= acc_q;
					status_o_q      <= status_q;
					bin_sum_q       <= (mode_q == MODE_READ) ? rec_q.sum : '0;
					bin_entries_q   <= (mode_q == MODE_READ) ? rec_q.cnt : '0;
					bin_mean_q      <= mean_q;
					bin_std_q       <= std_q;
					bin_err_q       <= err_q;
					bin_sqrt_sum_q  <= rs_q;
					total_entries_q <= tot_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign accepted      = accepted_q;
	assign status        = status_o_q;
	assign bin_sum       = bin_sum_q;
	assign bin_entries   = bin_entries_q;
	assign bin_mean      = bin_mean_q;
	assign bin_std       = bin_std_q;
	assign bin_err       = bin_err_q;
	assign bin_sqrt_sum  = bin_sqrt_sum_q;
	assign total_entries = total_entries_q;

	`WHP_AST_IMP(a_start_unit_free, req.start, !rsp.busy)
	`WHP_AST_IMP(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE))
	`WHP_AST_NXT(a_written_bin_valid, ram_we, vld_q[bin_q])

endmodule
`default_nettype wire
